[design/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, control codes and the microprogram of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int FIELD_W   = 13;
    localparam int HEADER_W  = 14;
    localparam int STEP_W    = 4;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [FIELD_W-1:0]     request_size;
        logic [FIELD_W-1:0]     release_address;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0]     block_address;
        logic                   granted;
        logic [FIELD_W-1:0]     free_count;
        logic [FIELD_W-1:0]     lowest_free_count;
    } out_word_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_CLEAR,
        DP_READ,
        DP_ADV,
        DP_APPEND,
        DP_HIT,
        DP_EMIT,
        DP_REL_ADDR,
        DP_RELEASE
    } dp_op_t;

    typedef enum logic [3:0] {
        CND_ALWAYS,
        CND_IN_VALID,
        CND_MODE,
        CND_REFUSE,
        CND_WALK_END,
        CND_HIT,
        CND_STOP,
        CND_REL_BAD,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic request_valid;
        logic mode_release;
        logic refuse;
        logic walk_end;
        logic hit;
        logic stop;
        logic rel_bad;
        logic out_busy;
    } seq_flags_t;

    typedef struct packed {
        dp_op_t             op;
        cond_t              cond;
        logic               invert;
        logic [STEP_W-1:0]  target;
    } ucode_word_t;

    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_TEST      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_EXAMINE   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADV       = 4'd5;
    localparam logic [STEP_W-1:0] STEP_APPEND    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_HIT       = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT_WAIT = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_REL_CHK   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_REL_DO    = 4'd11;

    // jump to target when (cond ^ invert), else fall through to the next step
    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        case (step)
            STEP_IDLE:      w = '{DP_LATCH,    CND_IN_VALID, 1'b1, STEP_IDLE};
            STEP_DISPATCH:  w = '{DP_CLEAR,    CND_MODE,     1'b0, STEP_REL_CHK};
            STEP_CHECK:     w = '{DP_NONE,     CND_REFUSE,   1'b0, STEP_EMIT_WAIT};
            STEP_TEST:      w = '{DP_READ,     CND_WALK_END, 1'b0, STEP_APPEND};
            STEP_EXAMINE:   w = '{DP_NONE,     CND_HIT,      1'b0, STEP_HIT};
            STEP_ADV:       w = '{DP_ADV,      CND_STOP,     1'b1, STEP_TEST};
            STEP_APPEND:    w = '{DP_APPEND,   CND_ALWAYS,   1'b0, STEP_EMIT_WAIT};
            STEP_HIT:       w = '{DP_HIT,      CND_ALWAYS,   1'b0, STEP_EMIT_WAIT};
            STEP_EMIT_WAIT: w = '{DP_NONE,     CND_OUT_BUSY, 1'b0, STEP_EMIT_WAIT};
            STEP_EMIT:      w = '{DP_EMIT,     CND_ALWAYS,   1'b0, STEP_IDLE};
            STEP_REL_CHK:   w = '{DP_REL_ADDR, CND_REL_BAD,  1'b0, STEP_EMIT_WAIT};
            STEP_REL_DO:    w = '{DP_RELEASE,  CND_ALWAYS,   1'b0, STEP_EMIT_WAIT};
            default:        w = '{DP_NONE,     CND_ALWAYS,   1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[design/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/ffha_seq.sv]
// ----------------------------------------------------------------------------
// ffha_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ffha_seq
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output dp_op_t     op
);

    logic [STEP_W-1:0] upc_reg;
    logic [STEP_W-1:0] upc_next;
    ucode_word_t       uword;
    logic              cond_val;

    assign uword = ucode_rom(upc_reg);
    assign op    = uword.op;

    always_comb
    begin
        case (uword.cond)
            CND_ALWAYS:   cond_val = 1'b1;
            CND_IN_VALID: cond_val = flags.request_valid;
            CND_MODE:     cond_val = flags.mode_release;
            CND_REFUSE:   cond_val = flags.refuse;
            CND_WALK_END: cond_val = flags.walk_end;
            CND_HIT:      cond_val = flags.hit;
            CND_STOP:     cond_val = flags.stop;
            CND_REL_BAD:  cond_val = flags.rel_bad;
            CND_OUT_BUSY: cond_val = flags.out_busy;
            default:      cond_val = 1'b1;
        endcase
        upc_next = (cond_val ^ uword.invert) ? uword.target : upc_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[design/ffha_datapath.sv]
// ----------------------------------------------------------------------------
// ffha_datapath
// Heap registers, header RAM, walk pointer arithmetic and result register.
// ----------------------------------------------------------------------------
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_op_t     op,
    input  logic       request_valid,
    input  in_word_t   request,
    output seq_flags_t flags,
    output logic       result_valid,
    input  logic       result_ready,
    output out_word_t  result
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int TW = $clog2(HEAP_BYTES + 1);
    localparam int PW = $clog2(HEAP_BYTES + 16384);
    localparam logic [FIELD_W-1:0] FREE_INIT = FIELD_W'(HEAP_BYTES % 8192);
    localparam logic [PW-1:0]      HEAP_P    = PW'(HEAP_BYTES);
    localparam logic [PW-1:0]      HDR_P     = PW'(HEADER_BYTES);

    logic                 mode_reg,  mode_next;
    logic [FIELD_W-1:0]   req_reg,   req_next;
    logic [FIELD_W-1:0]   rel_reg,   rel_next;
    logic [PW-1:0]        cur_reg,   cur_next;
    logic [TW-1:0]        top_reg,   top_next;
    logic [FIELD_W-1:0]   free_reg,  free_next;
    logic [FIELD_W-1:0]   low_reg,   low_next;
    logic [FIELD_W-1:0]   addr_reg,  addr_next;
    logic                 ok_reg,    ok_next;
    logic                 rv_reg,    rv_next;
    out_word_t            res_reg,   res_next;

    logic [HEADER_W-1:0]  rd_data;
    logic [HEADER_W-1:0]  wr_data;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;

    logic [FIELD_W-1:0]   sz;
    logic                 avail;
    logic [HEADER_W-1:0]  wanted;
    logic [PW-1:0]        append_end;
    logic                 room;
    logic [PW-1:0]        rel_idx;
    logic [PW-1:0]        hit_addr;
    logic [PW-1:0]        top_addr;
    logic [HEADER_W-1:0]  take_n;
    logic [HEADER_W-1:0]  take_diff;
    logic [FIELD_W-1:0]   take_res;
    logic [HEADER_W-1:0]  rel_sum;
    logic [FIELD_W-1:0]   rel_sat;
    logic [FIELD_W-1:0]   low_min;

    assign sz         = rd_data[FIELD_W-1:0];
    assign avail      = rd_data[HEADER_W-1];
    assign wanted     = {1'b0, req_reg} + HEADER_W'(HEADER_BYTES);
    assign append_end = PW'(top_reg) + PW'(wanted);
    assign room       = append_end <= HEAP_P;
    assign rel_idx    = PW'(rel_reg) - HDR_P;
    assign hit_addr   = cur_reg + HDR_P;
    assign top_addr   = PW'(top_reg) + HDR_P;
    assign take_n     = (op == DP_HIT) ? {1'b0, sz} : wanted;
    assign take_diff  = {1'b0, free_reg} - take_n;
    assign take_res   = (take_n > {1'b0, free_reg}) ? '0 : take_diff[FIELD_W-1:0];
    assign rel_sum    = {1'b0, free_reg} + {1'b0, sz};
    assign rel_sat    = rel_sum[HEADER_W-1] ? '1 : rel_sum[FIELD_W-1:0];
    assign low_min    = (free_reg < low_reg) ? free_reg : low_reg;

    assign flags.request_valid = request_valid;
    assign flags.mode_release  = (mode_reg == MODE_RELEASE);
    assign flags.refuse        = (req_reg == '0) || (req_reg > free_reg);
    assign flags.walk_end      = !((cur_reg < PW'(top_reg)) && (cur_reg < HEAP_P));
    assign flags.hit           = avail && ({1'b0, sz} >= wanted);
    assign flags.stop          = (sz == '0);
    assign flags.rel_bad       = (PW'(rel_reg) < HDR_P) || (rel_idx >= HEAP_P);
    assign flags.out_busy      = rv_reg && !result_ready;

    assign rd_en   = (op == DP_READ) || (op == DP_REL_ADDR);
    assign rd_addr = (op == DP_REL_ADDR) ? rel_idx[AW-1:0] : cur_reg[AW-1:0];
    assign wr_en   = (op == DP_HIT) || (op == DP_RELEASE) || ((op == DP_APPEND) && room);
    assign wr_addr = (op == DP_APPEND) ? top_reg[AW-1:0] : cur_reg[AW-1:0];

    always_comb
    begin
        case (op)
            DP_HIT:     wr_data = {1'b0, sz};
            DP_RELEASE: wr_data = {1'b1, sz};
            DP_APPEND:  wr_data = {1'b0, wanted[FIELD_W-1:0]};
            default:    wr_data = {1'b0, sz};
        endcase
    end

    ffha_ram #(
        .WIDTH (HEADER_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mode_next = mode_reg;
        req_next  = req_reg;
        rel_next  = rel_reg;
        cur_next  = cur_reg;
        top_next  = top_reg;
        free_next = free_reg;
        low_next  = low_reg;
        addr_next = addr_reg;
        ok_next   = ok_reg;
        res_next  = res_reg;
        rv_next   = rv_reg && !result_ready;
        case (op)
            DP_LATCH:
            begin
                mode_next = request.mode;
                req_next  = request.request_size;
                rel_next  = request.release_address;
            end
            DP_CLEAR:
            begin
                cur_next  = '0;
                addr_next = '0;
                ok_next   = 1'b0;
            end
            DP_ADV:
            begin
                cur_next = cur_reg + PW'(sz);
            end
            DP_HIT:
            begin
                addr_next = hit_addr[FIELD_W-1:0];
                free_next = take_res;
                ok_next   = 1'b1;
            end
            DP_APPEND:
            begin
                if (room)
                begin
                    addr_next = top_addr[FIELD_W-1:0];
                    top_next  = append_end[TW-1:0];
                    free_next = take_res;
                    ok_next   = 1'b1;
                end
            end
            DP_REL_ADDR:
            begin
                cur_next = rel_idx;
            end
            DP_RELEASE:
            begin
                free_next = rel_sat;
                ok_next   = 1'b1;
            end
            DP_EMIT:
            begin
                res_next.block_address     = addr_reg;
                res_next.granted           = ok_reg;
                res_next.free_count        = free_reg;
                res_next.lowest_free_count = low_min;
                low_next                   = low_min;
                rv_next                    = 1'b1;
            end
            default:
            begin
                rv_next = rv_reg && !result_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            free_reg <= FREE_INIT;
            low_reg  <= FREE_INIT;
            rv_reg   <= 1'b0;
        end
        else
        begin
            top_reg  <= top_next;
            free_reg <= free_next;
            low_reg  <= low_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        req_reg  <= req_next;
        rel_reg  <= rel_next;
        cur_reg  <= cur_next;
        addr_reg <= addr_next;
        ok_reg   <= ok_next;
        res_reg  <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    a_low_le_free: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (res_reg.lowest_free_count <= res_reg.free_count))
        else $error("lowest free count above free count");

    a_top_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(top_reg) <= HEAP_P)
        else $error("top pointer past heap end");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (op == DP_EMIT) |=> rv_reg)
        else $error("emit step did not raise result valid");

    a_refused_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !res_reg.granted) |-> (res_reg.block_address == '0))
        else $error("refused word carries an address");

endmodule

[design/first_fit_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator, microcoded over a header RAM.
// ----------------------------------------------------------------------------
// request channel (valid/ready): one word is an allocate (mode 0) or a release
// (mode 1). result channel (valid/ready): exactly one word per request, in
// order, with block address, granted flag, free count and lowest free count.
// One request is in flight at a time; request_ready is high only while the
// sequencer sits in its idle step. A finished word waits in the result
// register and the next request is already taken while it waits.
// An allocate walks the headers from the start and reuses the first free one
// that fits, else appends at the top if room remains; a release or a refusal
// walks none.
// The next request can be taken in the same cycle that result_valid rises.
// The walk reads one header per pass through the single RAM read port.
// Reset empties the heap (top pointer 0, free counts HEAP_BYTES mod 8192) at once;
// the header RAM is not cleared. A stalled receiver holds the sequencer before
// its emit step; nothing is dropped.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      request_valid,
    output logic      request_ready,
    input  in_word_t  request,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    dp_op_t     op;
    seq_flags_t flags;

    assign request_ready = (op == DP_LATCH);

    ffha_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .request_valid (request_valid),
        .request       (request),
        .flags         (flags),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

[tb/sv/first_fit_heap_allocator_unit_test.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_test
// Self-checking bench for the first-fit heap allocator. Request words are
// mirrored into a software copy of the header chain and counters, which works
// out the result word in order; returned words are compared field by field.
// Directed corners come first, then random allocate/release traffic against
// live blocks, then a heap-end fill and a free-count saturation run. Both
// channels idle at random, with one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_test;
    import ffha_pkg::*;

    localparam int HEAP_BYTES      = 4096;
    localparam int HEADER_BYTES    = 8;
    localparam int COUNT_MAX       = (1 << FIELD_W) - 1;
    localparam int RANDOM_WORDS    = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int RUN_LIMIT       = 20_000_000;

    typedef enum int {
        READY_OPEN,
        READY_RANDOM,
        READY_SPARSE
    } ready_style_t;

    logic      clk;
    logic      rst_n;
    logic      request_valid;
    logic      request_ready;
    in_word_t  request;
    logic      result_valid;
    logic      result_ready;
    out_word_t result;

    class heap_ledger;
        logic [HEADER_W-1:0] header_mirror [HEAP_BYTES];
        int unsigned         top_mirror;
        int unsigned         free_mirror;
        int unsigned         lowest_mirror;
        int unsigned         chain_offsets [$];
        out_word_t           grant_queue [$];
        int                  mismatches;

        function new();
            foreach (header_mirror[i])
                header_mirror[i] = '0;
            top_mirror    = 0;
            free_mirror   = HEAP_BYTES & COUNT_MAX;
            lowest_mirror = HEAP_BYTES & COUNT_MAX;
            mismatches    = 0;
        endfunction

        function void consume_bytes(int unsigned n);
            free_mirror = (n > free_mirror) ? 0 : free_mirror - n;
            if (free_mirror < lowest_mirror)
                lowest_mirror = free_mirror;
        endfunction

        function void take_request(in_word_t w);
            out_word_t   r;
            int unsigned wanted;
            int unsigned cur;
            int unsigned sz;
            int unsigned rel;
            bit          found;
            bit          stop;
            r     = '0;
            found = 1'b0;
            stop  = 1'b0;
            rel   = 32'(w.release_address);
            if (w.mode == MODE_ALLOC)
            begin
                if (w.request_size != 0 && w.request_size <= free_mirror)
                begin
                    wanted = w.request_size + HEADER_BYTES;
                    cur    = 0;
                    while (!found && !stop && cur < top_mirror && cur < HEAP_BYTES)
                    begin
                        sz = 32'(header_mirror[cur][FIELD_W-1:0]);
                        if (header_mirror[cur][HEADER_W-1] && sz >= wanted)
                        begin
                            header_mirror[cur] = {1'b0, sz[FIELD_W-1:0]};
                            r.block_address    = FIELD_W'(cur + HEADER_BYTES);
                            consume_bytes(sz);
                            found = 1'b1;
                        end
                        else if (sz == 0)
                            stop = 1'b1;
                        else
                            cur += sz;
                    end
                    if (found)
                        r.granted = 1'b1;
                    else if (top_mirror + wanted <= HEAP_BYTES)
                    begin
                        header_mirror[top_mirror] = {1'b0, wanted[FIELD_W-1:0]};
                        chain_offsets.push_back(top_mirror);
                        r.block_address = FIELD_W'(top_mirror + HEADER_BYTES);
                        top_mirror += wanted;
                        consume_bytes(wanted);
                        r.granted = 1'b1;
                    end
                end
            end
            else if (rel >= HEADER_BYTES && rel - HEADER_BYTES < HEAP_BYTES)
            begin
                sz = 32'(header_mirror[rel - HEADER_BYTES][FIELD_W-1:0]);
                free_mirror += sz;
                if (free_mirror > COUNT_MAX)
                    free_mirror = COUNT_MAX;
                header_mirror[rel - HEADER_BYTES] = {1'b1, sz[FIELD_W-1:0]};
                r.granted = 1'b1;
            end
            r.free_count        = free_mirror[FIELD_W-1:0];
            r.lowest_free_count = lowest_mirror[FIELD_W-1:0];
            grant_queue.push_back(r);
        endfunction

        function void compare_field(string name, logic [FIELD_W-1:0] want,
                                    logic [FIELD_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(out_word_t got);
            out_word_t want;
            if (grant_queue.size() == 0)
            begin
                $error("result word with no request waiting: %h", got);
                mismatches++;
            end
            else
            begin
                want = grant_queue.pop_front();
                compare_field("block_address", want.block_address, got.block_address);
                compare_field("granted", FIELD_W'(want.granted), FIELD_W'(got.granted));
                compare_field("free_count", want.free_count, got.free_count);
                compare_field("lowest_free_count", want.lowest_free_count,
                              got.lowest_free_count);
            end
        endfunction
    endclass

    heap_ledger ledger;
    bit         hold_off;
    bit         offering;
    int         burst_left;

    first_fit_heap_allocator_unit #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic in_word_t make_word(logic mode, int unsigned size,
                                           int unsigned addr);
        in_word_t w;
        w.mode            = mode;
        w.request_size    = size[FIELD_W-1:0];
        w.release_address = addr[FIELD_W-1:0];
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned avail_q [$];
        int unsigned busy_q [$];
        int unsigned off;
        int unsigned sz;
        int unsigned trim;
        int unsigned pick;
        w = make_word(MODE_ALLOC, $urandom_range(0, COUNT_MAX),
                      $urandom_range(0, COUNT_MAX));
        foreach (ledger.chain_offsets[i])
        begin
            off = ledger.chain_offsets[i];
            if (ledger.header_mirror[off][HEADER_W-1])
                avail_q.push_back(off);
            else
                busy_q.push_back(off);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15 && avail_q.size() > 0)
            begin
                // aim at a free block so the walk finds a hit
                off  = avail_q[$urandom_range(0, avail_q.size() - 1)];
                sz   = 32'(ledger.header_mirror[off][FIELD_W-1:0]);
                trim = $urandom_range(0, 3);
                if (sz - HEADER_BYTES > trim)
                    w.request_size = FIELD_W'(sz - HEADER_BYTES - trim);
                else
                    w.request_size = FIELD_W'(sz - HEADER_BYTES);
            end
            else if (pick < 80)
                w.request_size = FIELD_W'($urandom_range(1, 120));
            else if (pick < 93)
                w.request_size = FIELD_W'($urandom_range(121, 600));
        end
        else if (pick < 90 && ledger.chain_offsets.size() > 0)
        begin
            w.mode = MODE_RELEASE;
            if (busy_q.size() > 0 && $urandom_range(0, 9) != 0)
                off = busy_q[$urandom_range(0, busy_q.size() - 1)];
            else
                off = ledger.chain_offsets[$urandom_range(0, ledger.chain_offsets.size() - 1)];
            w.release_address = FIELD_W'(off + HEADER_BYTES);
        end
        else
        begin
            w.mode = MODE_RELEASE;
            if ($urandom_range(0, 1) == 0)
                w.release_address = FIELD_W'($urandom_range(0, HEADER_BYTES - 1));
            else
                w.release_address =
                    FIELD_W'($urandom_range(HEAP_BYTES + HEADER_BYTES, COUNT_MAX));
        end
        return w;
    endfunction

    task automatic lower_valid();
        if (offering)
        begin
            request_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic offer_word(input in_word_t w);
        int gap;
        request_valid <= 1'b1;
        request       <= w;
        offering = 1'b1;
        @(posedge clk);
        while (!request_ready)
            @(posedge clk);
        ledger.take_request(w);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0:       gap = $urandom_range(16, 60);
                1, 2, 3: gap = $urandom_range(3, 15);
                default: gap = $urandom_range(0, 2);
            endcase
            if (gap > 0)
            begin
                lower_valid();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_for_drain();
        lower_valid();
        while (ledger.grant_queue.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stall pattern plus one long hold-off on request
    initial
    begin
        ready_style_t style;
        int           seg_left;
        int           hold_left;
        result_ready = 1'b0;
        style        = READY_OPEN;
        seg_left     = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                ledger.match_result(result);
            if (hold_off)
            begin
                hold_off  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = ready_style_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (style)
                    READY_OPEN:   result_ready <= 1'b1;
                    READY_RANDOM: result_ready <= ($urandom_range(0, 1) == 1);
                    default:      result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        in_word_t    directed [$];
        in_word_t    w;
        int          counted;
        int unsigned spare;
        int unsigned widest;
        int          repeats;
        ledger        = new();
        hold_off      = 1'b0;
        offering      = 1'b0;
        burst_left    = 0;
        rst_n         = 1'b0;
        request_valid = 1'b0;
        request       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_word(MODE_ALLOC, 0, 0));
        directed.push_back(make_word(MODE_ALLOC, COUNT_MAX, COUNT_MAX));
        directed.push_back(make_word(MODE_ALLOC, HEAP_BYTES + 1, 0));
        directed.push_back(make_word(MODE_RELEASE, 0, 0));
        directed.push_back(make_word(MODE_RELEASE, COUNT_MAX, HEADER_BYTES - 1));
        directed.push_back(make_word(MODE_RELEASE, 0, HEAP_BYTES + HEADER_BYTES));
        directed.push_back(make_word(MODE_RELEASE, 0, COUNT_MAX));
        // blocks at 0 (9 bytes), 9 (108 bytes), 117 (48 bytes)
        directed.push_back(make_word(MODE_ALLOC, 1, 0));
        directed.push_back(make_word(MODE_ALLOC, 100, 0));
        directed.push_back(make_word(MODE_ALLOC, 40, 0));
        directed.push_back(make_word(MODE_RELEASE, 0, 17));
        directed.push_back(make_word(MODE_ALLOC, 50, 0));
        directed.push_back(make_word(MODE_RELEASE, 0, 125));
        directed.push_back(make_word(MODE_RELEASE, 0, 125));
        directed.push_back(make_word(MODE_RELEASE, 0, 17));
        directed.push_back(make_word(MODE_RELEASE, 0, 8));
        // too small at 0, whole reuse at 9, exact fit at 117, then at 0, then append
        directed.push_back(make_word(MODE_ALLOC, 2, 0));
        directed.push_back(make_word(MODE_ALLOC, 40, 0));
        directed.push_back(make_word(MODE_ALLOC, 1, 0));
        directed.push_back(make_word(MODE_ALLOC, 3, 0));
        foreach (directed[i])
            offer_word(directed[i]);

        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            w = random_word();
            offer_word(w);
            if (!(w.mode == MODE_RELEASE &&
                  (w.release_address < HEADER_BYTES ||
                   w.release_address >= HEAP_BYTES + HEADER_BYTES)))
            begin
                counted++;
                if (counted == 500)
                    hold_off = 1'b1;
                if (counted == 1200)
                    wait_for_drain();
            end
        end

        // heap end: one byte past the top, then an exact fill
        if (ledger.top_mirror + HEADER_BYTES < HEAP_BYTES)
        begin
            spare = HEAP_BYTES - ledger.top_mirror - HEADER_BYTES;
            offer_word(make_word(MODE_ALLOC, spare + 1, 0));
        end
        if (ledger.top_mirror + HEADER_BYTES < HEAP_BYTES)
        begin
            spare = HEAP_BYTES - ledger.top_mirror - HEADER_BYTES;
            offer_word(make_word(MODE_ALLOC, spare, 0));
        end

        // free count saturation by releasing the widest block over and over
        widest = ledger.chain_offsets[0];
        foreach (ledger.chain_offsets[i])
            if (ledger.header_mirror[ledger.chain_offsets[i]][FIELD_W-1:0] >
                ledger.header_mirror[widest][FIELD_W-1:0])
                widest = ledger.chain_offsets[i];
        repeats = 0;
        while (ledger.free_mirror < COUNT_MAX && repeats < 64)
        begin
            offer_word(make_word(MODE_RELEASE, $urandom_range(0, COUNT_MAX),
                                 widest + HEADER_BYTES));
            repeats++;
        end
        offer_word(make_word(MODE_ALLOC, 1, 0));

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
